>>> sv/sonar_sliding_median_filter_core_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the sliding median filter
// clocked on clk, quiet while rst_n is low, or always checked
// ----------------------------------------------------------------------------
`ifndef SONAR_SLIDING_MEDIAN_FILTER_CORE_ASSERT_SVH
`define SONAR_SLIDING_MEDIAN_FILTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define SSMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SSMF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSMF_ASSERT(lbl, prop, msg)
`define SSMF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> sv/ssmf_pkg.sv
// ----------------------------------------------------------------------------
// ssmf_pkg
// shared constants, types and state codes of the sliding median filter
// ----------------------------------------------------------------------------
package ssmf_pkg;

  localparam int unsigned DIST_W      = 16;
  localparam int unsigned WINDOW      = 5;
  localparam int unsigned IDX_W       = $clog2(WINDOW);
  localparam int unsigned WPOS_W      = $clog2(WINDOW + 1);
  localparam int unsigned MID_LO      = (WINDOW - 1) / 2;
  localparam int unsigned MID_HI      = WINDOW / 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIST_W-1:0] MIN_VALID_RESET = 16'd5;

  // one classified sample handed from front to back
  typedef struct packed {
    logic [DIST_W-1:0] sample;
    logic [DIST_W-1:0] kept;
    logic [IDX_W-1:0]  pos;
    logic              full;
  } ssmf_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RANK,
    BK_DONE
  } ssmf_back_state_t;

endpackage

>>> sv/ssmf_ifs.sv
// ----------------------------------------------------------------------------
// ssmf channel interfaces
// sample input, filtered result and configuration write channels
// ----------------------------------------------------------------------------
interface ssmf_in_if;
  logic                           valid;
  logic                           ready;
  logic [ssmf_pkg::DIST_W-1:0]    sample_distance;

  modport source (output valid, output sample_distance, input ready);
  modport sink   (input valid, input sample_distance, output ready);
endinterface

interface ssmf_out_if;
  logic                           valid;
  logic                           ready;
  logic [ssmf_pkg::DIST_W-1:0]    filtered_distance;
  logic                           median_valid;

  modport source (output valid, output filtered_distance, output median_valid, input ready);
  modport sink   (input valid, input filtered_distance, input median_valid, output ready);
endinterface

interface ssmf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ssmf_pkg::DIST_W-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/ssmf_front.sv
// ----------------------------------------------------------------------------
// ssmf_front
// accepts samples, replaces invalid ones and assigns window slots
// ----------------------------------------------------------------------------
module ssmf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  ssmf_in_if.sink              in_ch,
  ssmf_cfg_if.sink             cfg_ch,
  output logic                 push_valid,
  input  logic                 push_ready,
  output ssmf_pkg::ssmf_job_t  push_job
);

  logic [ssmf_pkg::DIST_W-1:0] min_valid_r;
  logic [ssmf_pkg::WPOS_W-1:0] wpos_r, wpos_nxt;
  logic                        full_r, full_nxt;
  logic [ssmf_pkg::DIST_W-1:0] last_r, last_nxt;

  logic                        wrap;
  logic [ssmf_pkg::WPOS_W-1:0] pos;
  logic [ssmf_pkg::DIST_W-1:0] kept;
  logic                        accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign push_valid   = in_ch.valid;
  assign accept       = in_ch.valid && push_ready;

  always_comb begin
    wrap     = (wpos_r >= ssmf_pkg::WPOS_W'(ssmf_pkg::WINDOW));
    pos      = wrap ? '0 : wpos_r;
    kept     = (in_ch.sample_distance > min_valid_r) ? in_ch.sample_distance : last_r;
    wpos_nxt = pos + ssmf_pkg::WPOS_W'(1);
    full_nxt = full_r || wrap;
    last_nxt = kept;
  end

  always_comb begin
    push_job.sample = in_ch.sample_distance;
    push_job.kept   = kept;
    push_job.pos    = pos[ssmf_pkg::IDX_W-1:0];
    push_job.full   = full_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_valid_r <= ssmf_pkg::MIN_VALID_RESET;
    end else if (cfg_ch.valid) begin
      min_valid_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
      full_r <= 1'b0;
      last_r <= '0;
    end else if (accept) begin
      wpos_r <= wpos_nxt;
      full_r <= full_nxt;
      last_r <= last_nxt;
    end
  end

endmodule

>>> sv/ssmf_queue.sv
// ----------------------------------------------------------------------------
// ssmf_queue
// short fifo of classified samples between front and back
// ----------------------------------------------------------------------------
module ssmf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  ssmf_pkg::ssmf_job_t  push_job,
  output logic                 pop_valid,
  input  logic                 pop,
  output ssmf_pkg::ssmf_job_t  pop_job
);

  ssmf_pkg::ssmf_job_t         slot_r [ssmf_pkg::QUEUE_DEPTH];
  logic [ssmf_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ssmf_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ssmf_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = (count_r != ssmf_pkg::QCNT_W'(ssmf_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ssmf_pkg::QPTR_W'(ssmf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + ssmf_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ssmf_pkg::QPTR_W'(ssmf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + ssmf_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + ssmf_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - ssmf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/ssmf_back.sv
// ----------------------------------------------------------------------------
// ssmf_back
// window store, rank-count median search and output register
// ----------------------------------------------------------------------------
`include "sonar_sliding_median_filter_core_assert.svh"

module ssmf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop,
  input  ssmf_pkg::ssmf_job_t  pop_job,
  ssmf_out_if.source           out_ch
);

  ssmf_pkg::ssmf_back_state_t  state_r, state_nxt;

  logic [ssmf_pkg::DIST_W-1:0] store_r [ssmf_pkg::WINDOW];
  logic [ssmf_pkg::IDX_W-1:0]  rank_cnt_r, rank_cnt_nxt;
  logic [ssmf_pkg::DIST_W-1:0] sample_r;
  logic                        full_job_r;
  logic [ssmf_pkg::DIST_W-1:0] lo_r, hi_r;
  logic                        out_valid_r;
  logic [ssmf_pkg::DIST_W-1:0] out_dist_r;
  logic                        out_med_r;

  logic                        out_free;
  logic                        rank_step;
  logic                        out_load;
  logic [ssmf_pkg::DIST_W-1:0] cand;
  logic [ssmf_pkg::WINDOW-1:0] below;
  logic [ssmf_pkg::IDX_W-1:0]  rank;
  logic [ssmf_pkg::DIST_W:0]   mid_sum;
  logic [ssmf_pkg::DIST_W-1:0] result;

  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssmf_pkg::BK_IDLE: begin
        if (pop_valid) begin
          state_nxt = pop_job.full ? ssmf_pkg::BK_RANK : ssmf_pkg::BK_DONE;
        end
      end
      ssmf_pkg::BK_RANK: begin
        if (rank_cnt_r == ssmf_pkg::IDX_W'(ssmf_pkg::WINDOW - 1)) begin
          state_nxt = ssmf_pkg::BK_DONE;
        end
      end
      ssmf_pkg::BK_DONE: begin
        if (out_free) begin
          state_nxt = ssmf_pkg::BK_IDLE;
        end
      end
      default: state_nxt = ssmf_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop       = 1'b0;
    rank_step = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ssmf_pkg::BK_IDLE: pop       = pop_valid;
      ssmf_pkg::BK_RANK: rank_step = 1'b1;
      ssmf_pkg::BK_DONE: out_load  = out_free;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // rank of the candidate: entries below it, ties broken by slot order
  always_comb begin
    cand = store_r[rank_cnt_r];
    for (int j = 0; j < ssmf_pkg::WINDOW; j++) begin
      below[j] = (store_r[j] < cand) ||
                 ((store_r[j] == cand) && (ssmf_pkg::IDX_W'(j) < rank_cnt_r));
    end
    rank = ssmf_pkg::IDX_W'($countones(below));
  end

  always_comb begin
    // counter returns to zero after the last candidate
    rank_cnt_nxt = (rank_step && (rank_cnt_r != ssmf_pkg::IDX_W'(ssmf_pkg::WINDOW - 1))) ?
                   rank_cnt_r + ssmf_pkg::IDX_W'(1) : '0;
    mid_sum      = {1'b0, lo_r} + {1'b0, hi_r};
    result       = full_job_r ? mid_sum[ssmf_pkg::DIST_W:1] : sample_r;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      store_r[pop_job.pos] <= pop_job.kept;
      sample_r             <= pop_job.sample;
      full_job_r           <= pop_job.full;
    end
    if (rank_step && (rank == ssmf_pkg::IDX_W'(ssmf_pkg::MID_LO))) begin
      lo_r <= cand;
    end
    if (rank_step && (rank == ssmf_pkg::IDX_W'(ssmf_pkg::MID_HI))) begin
      hi_r <= cand;
    end
    if (out_load) begin
      out_dist_r <= result;
      out_med_r  <= full_job_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssmf_pkg::BK_IDLE;
      rank_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rank_cnt_r <= rank_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.filtered_distance = out_dist_r;
  assign out_ch.median_valid      = out_med_r;

  `SSMF_ASSERT(a_rank_only_full, (state_r == ssmf_pkg::BK_RANK) |-> full_job_r, "rank pass on a filling window")
  `SSMF_ASSERT(a_out_from_done, $rose(out_valid_r) |-> ($past(state_r) == ssmf_pkg::BK_DONE), "result appeared outside done")
  `SSMF_ASSERT(a_done_to_idle, (state_r == ssmf_pkg::BK_DONE && out_free) |=> (state_r == ssmf_pkg::BK_IDLE && out_valid_r), "done did not hand off result")
  `SSMF_ASSERT(a_rank_cnt_range, rank_cnt_r <= ssmf_pkg::IDX_W'(ssmf_pkg::WINDOW - 1), "rank counter past window")

endmodule

>>> sv/sonar_sliding_median_filter_core.sv
// ----------------------------------------------------------------------------
// sonar_sliding_median_filter_core
// sliding window median of sonar distance samples with invalid-sample hold
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                              | transfer when
//  ---------+-----+--------------------------------------+----------------------
//  in_ch    | in  | sample_distance[15:0]                | valid && ready
//  out_ch   | out | filtered_distance[15:0], median_valid| valid && ready
//  cfg_ch   | in  | data[15:0] -> min_valid_distance     | valid && ready
//
//  a sample taken while the window is filling goes from idle straight to done
//  in the back part, one taken once the window is full passes idle, rank and done:
//  the rank search walks one candidate per cycle over the window registers
//  front accepts in the same cycle the queue has room, so up to two samples
//  wait while the back ranks and the output register waits on out_ch.ready
//  rst_n is synchronous, active low; min_valid_distance resets to 5, the
//  window slots carry no reset and are all written before the first median
//  cfg_ch is always ready; writes are expected only while the block is idle
//
`include "sonar_sliding_median_filter_core_assert.svh"

module sonar_sliding_median_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  ssmf_in_if.sink     in_ch,
  ssmf_out_if.source  out_ch,
  ssmf_cfg_if.sink    cfg_ch
);

  // front to queue
  logic                 push_valid;
  logic                 push_ready;
  ssmf_pkg::ssmf_job_t  push_job;

  // queue to back
  logic                 pop_valid;
  logic                 pop;
  ssmf_pkg::ssmf_job_t  pop_job;

  // classify: hold last kept value for invalid samples, pick the slot
  ssmf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // decouples sample intake from the median search
  ssmf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_job    (pop_job)
  );

  // window write, rank search and registered result
  ssmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

  // nothing enters the queue unless the front saw room
  `SSMF_ASSERT(a_push_has_room, push_valid && push_ready |-> in_ch.ready, "push without intake handshake")
  // no job, filling or full, carries a slot index beyond the window
  `SSMF_ASSERT(a_slot_in_range, pop_valid |-> (pop_job.pos <= ssmf_pkg::IDX_W'(ssmf_pkg::WINDOW - 1)), "slot index out of window")
  // a pop only happens on a waiting job
  `SSMF_ASSERT(a_pop_on_valid, pop |-> pop_valid, "pop from empty queue")

endmodule

>>> verif/ssmf_median_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssmf_median_checker
// watches the sample, result and threshold channels of the median filter,
// keeps its own window and threshold, and compares every result transfer
// ----------------------------------------------------------------------------
module ssmf_median_checker (
  input  logic  clk,
  input  logic  rst_n,
  ssmf_in_if    in_mon,
  ssmf_out_if   out_mon,
  ssmf_cfg_if   cfg_mon,
  output int    fail_count,
  output int    pending
);
  import ssmf_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              median_ok;
  } filt_result_t;

  logic [DIST_W-1:0] ring [WINDOW];
  int unsigned       slot;
  logic              ring_full;
  logic [DIST_W-1:0] held_sample;
  logic [DIST_W-1:0] floor_dist;
  filt_result_t      filtered_q [$];
  int                mismatches;

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
  end

  // middle of the sorted window, mean of the two middles for an even window
  function automatic logic [DIST_W-1:0] window_middle();
    logic [DIST_W-1:0] sorted [WINDOW];
    logic [DIST_W-1:0] v;
    logic [DIST_W:0]   sum;
    int                b;
    for (int i = 0; i < WINDOW; i++) sorted[i] = ring[i];
    for (int a = 1; a < WINDOW; a++) begin
      v = sorted[a];
      b = a;
      while (b > 0 && sorted[b-1] > v) begin
        sorted[b] = sorted[b-1];
        b--;
      end
      sorted[b] = v;
    end
    if ((WINDOW % 2) == 0) begin
      sum = {1'b0, sorted[MID_LO]} + {1'b0, sorted[MID_HI]};
      return sum[DIST_W:1];
    end
    return sorted[MID_HI];
  endfunction

  function automatic filt_result_t next_result(logic [DIST_W-1:0] raw);
    filt_result_t      r;
    logic [DIST_W-1:0] kept;
    if (slot >= WINDOW) begin
      slot      = 0;
      ring_full = 1'b1;
    end
    kept        = (raw > floor_dist) ? raw : held_sample;
    ring[slot]  = kept;
    held_sample = kept;
    r.distance  = ring_full ? window_middle() : raw;
    r.median_ok = ring_full;
    slot++;
    return r;
  endfunction

  always @(posedge clk) begin : track
    filt_result_t got;
    filt_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) ring[i] = '0;
      slot        = 0;
      ring_full   = 1'b0;
      held_sample = '0;
      floor_dist  = MIN_VALID_RESET;
      filtered_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) floor_dist = cfg_mon.data;
      // a result never leaves in the cycle its sample arrives, so pop first
      if (out_mon.valid && out_mon.ready) begin
        got.distance  = out_mon.filtered_distance;
        got.median_ok = out_mon.median_valid;
        if (filtered_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing pending: distance %0d median_valid %0b",
                     $time, got.distance, got.median_ok);
        end else begin
          want = filtered_q.pop_front();
          if (got.distance !== want.distance || got.median_ok !== want.median_ok) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: distance exp %0d got %0d, median_valid exp %0b got %0b",
                       $time, want.distance, got.distance, want.median_ok, got.median_ok);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        filtered_q.push_back(next_result(in_mon.sample_distance));
    end
    fail_count <= mismatches;
    pending    <= filtered_q.size();
  end

endmodule

>>> verif/tb_sonar_sliding_median_filter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sonar_sliding_median_filter_core
// drives samples and threshold writes into the median filter with random
// gaps and back pressure; a side checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_sonar_sliding_median_filter_core;
  import ssmf_pkg::*;

  localparam int PHASE_ITEMS = 200;   // random samples per threshold setting
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off, fills the block
  localparam int SETTLE      = 12;    // quiet cycles before a threshold write
  localparam int DRAIN       = 30;    // quiet cycles after the last result
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer at all

  logic clk = 1'b0;
  logic rst_n;

  ssmf_in_if  in_ch ();
  ssmf_out_if out_ch ();
  ssmf_cfg_if cfg_ch ();

  int fail_count;
  int pending;

  // sink side knobs, written with nonblocking so the sink sees them only after the edge they are written at
  logic sink_steady;
  int   hold_requests;

  // sender side knob, used only by the stimulus process
  bit   source_steady;

  // running center for clustered samples, so medians sit among close values
  logic [DIST_W-1:0] cluster_center;

  sonar_sliding_median_filter_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ssmf_median_checker median_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one sample transfer; valid stays high on return so back-to-back items
  // never drop and raise it in the same step
  task automatic send_sample(input logic [DIST_W-1:0] d);
    if (!source_steady) begin
      while ($urandom_range(99) < 36) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid           <= 1'b1;
    in_ch.sample_distance <= d;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering, let every pending result come out, then a short pause;
  // it waits on the clock first so the count includes the last sample taken
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_floor(input logic [DIST_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // mix of full random, threshold edges, extremes and clustered values
  function automatic logic [DIST_W-1:0] pick_sample(input logic [DIST_W-1:0] floor_v);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return DIST_W'($urandom);
    if (r < 50) return floor_v + DIST_W'($urandom_range(6)) - DIST_W'(3);
    if (r < 62) begin
      case ($urandom_range(3))
        0: return '0;
        1: return DIST_W'(1);
        2: return {DIST_W{1'b1}} - DIST_W'(1);
        default: return {DIST_W{1'b1}};
      endcase
    end
    if (r < 72) return DIST_W'($urandom_range(200));
    if ($urandom_range(15) == 0) cluster_center = DIST_W'($urandom);
    return cluster_center + DIST_W'($urandom_range(40)) - DIST_W'(20);
  endfunction

  // receiver: random ready, a steady stretch on request, and one long hold-off
  initial begin : result_sink
    int hold_left;
    int seen_holds;
    hold_left  = 0;
    seen_holds = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen_holds) begin
        seen_holds = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= sink_steady || ($urandom_range(99) >= 36);
      end
    end
  end

  // watchdog: any cycle out of reset without a transfer on any channel counts
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [DIST_W-1:0] opening [$];
    logic [DIST_W-1:0] floors  [$];
    logic [DIST_W-1:0] floor_v;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.sample_distance <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.data           <= '0;
    sink_steady           <= 1'b0;
    hold_requests         <= 0;
    source_steady         = 0;
    cluster_center        = 16'd1200;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset threshold of 5:
    // zero before anything stored falls back to the zero hold value,
    // a sample equal to the threshold is held, raw samples show while filling
    // (an invalid one too), the wrap turns on the median with the sixth sample
    opening = '{16'd0, 16'd5, 16'd6, 16'hFFFF, 16'd3,
                16'd100, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFE,
                16'd2, 16'd40000, 16'd1, 16'h5555, 16'hAAAA,
                16'h8000, 16'h7FFF, 16'd4, 16'd5, 16'd6};
    foreach (opening[i]) send_sample(opening[i]);
    drain_results();

    // threshold settings for the random part, extremes among them
    floors = '{16'd0, 16'hFFFF, DIST_W'($urandom), 16'hFFFE, MIN_VALID_RESET,
               16'd1, DIST_W'($urandom_range(300)), 16'h8000, DIST_W'($urandom)};
    foreach (floors[p]) begin
      floor_v = floors[p];
      write_floor(floor_v);
      @(posedge clk);

      source_steady = 0;
      sink_steady   <= 1'b0;
      if (p == 2) begin
        // back pressure: receiver holds off while the sender keeps offering
        source_steady = 1;
        hold_requests <= hold_requests + 1;
      end else if (p == 4) begin
        // a long stretch with no idling on either side
        source_steady = 1;
        sink_steady   <= 1'b1;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample(floor_v));
      source_steady = 0;
      sink_steady   <= 1'b0;
      drain_results();
    end

    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
